// File: rtl/core/weighted_pixel_stack_integrator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted pixel stack integrator.
// The macros check on the rising edge of clk and are disabled during rst.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PIXEL_STACK_INTEGRATOR_ASSERT_SVH
`define WEIGHTED_PIXEL_STACK_INTEGRATOR_ASSERT_SVH

// Condition in the same cycle implies the consequence in that cycle.
`define WPSI_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Condition in one cycle implies the consequence in the following cycle.
`define WPSI_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: rtl/core/wpsi_pkg.sv
// ----------------------------------------------------------------------------
// wpsi_pkg
// Shared types and constants of the weighted pixel stack integrator.
// ----------------------------------------------------------------------------
package wpsi_pkg;

  // Fixed field widths.
  localparam int VALUE_W       = 32;
  localparam int WEIGHT_W      = 16;
  localparam int SUPPORT_OUT_W = 31;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 9;
  localparam int PADDR_W       = 4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CAND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_REJECT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_WEIGHT = 3'd4;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_USE_WEIGHTS  = 2'd0;
  localparam logic [1:0] REG_USE_SUPPORT  = 2'd1;
  localparam logic [1:0] REG_USE_ACCEPTED = 2'd2;

  // Unit constants in fixed point.
  localparam logic [SUPPORT_OUT_W-1:0] ONE_Q16 = 31'd65536;
  localparam logic [WEIGHT_W-2:0]      ONE_Q8  = 15'd256;

  // Controller states.
  typedef enum logic [1:0] {
    S_ACCUM,
    S_DECIDE,
    S_DIV,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum_en;
    logic clear;
    logic div_start;
    logic div_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_needed;
    logic div_done;
  } dp_stat_t;

endpackage

// File: rtl/core/wpsi_if.sv
// ----------------------------------------------------------------------------
// wpsi_in_if / wpsi_out_if
// Valid/ready channels carrying candidate samples and stack results.
// ----------------------------------------------------------------------------
interface wpsi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        value_finite;
  logic [15:0] weight;
  logic        weight_finite;
  logic [31:0] support;
  logic        support_finite;
  logic        accepted;
  logic        last;
  logic        stack_empty;

  modport source (
    output valid, value, value_finite, weight, weight_finite, support,
           support_finite, accepted, last, stack_empty,
    input  ready
  );
  modport sink (
    input  valid, value, value_finite, weight, weight_finite, support,
           support_finite, accepted, last, stack_empty,
    output ready
  );
endinterface

interface wpsi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] signal;
  logic [30:0] support_out;
  logic [2:0]  status;
  logic [8:0]  candidate_count;
  logic [8:0]  accepted_count;
  logic [8:0]  finite_count;
  logic [8:0]  positive_weight_count;
  logic [8:0]  used_count;

  modport source (
    output valid, signal, support_out, status, candidate_count, accepted_count,
           finite_count, positive_weight_count, used_count,
    input  ready
  );
  modport sink (
    input  valid, signal, support_out, status, candidate_count, accepted_count,
           finite_count, positive_weight_count, used_count,
    output ready
  );
endinterface

// File: rtl/core/wpsi_ctrl.sv
// ----------------------------------------------------------------------------
// wpsi_ctrl
// Controller: sequences accumulation, the closing decision, the divide and
// the hand-over of the result.
// ----------------------------------------------------------------------------
module wpsi_ctrl
  import wpsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_close,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_ACCUM: begin
        if (in_valid && in_close) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = stat.div_needed ? S_DIV : S_RESP;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = S_ACCUM;
      end
      default: state_next = S_ACCUM;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state)
      S_ACCUM: begin
        in_ready     = 1'b1;
        cmd.accum_en = in_valid;
      end
      S_DECIDE: begin
        cmd.div_start = stat.div_needed;
      end
      S_DIV: begin
        cmd.div_step = !stat.div_done;
      end
      S_RESP: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/wpsi_datapath.sv
// ----------------------------------------------------------------------------
// wpsi_datapath
// Stack accumulators, counters, status decision and a restoring divider
// that forms the truncated weighted mean.
// ----------------------------------------------------------------------------
module wpsi_datapath
  import wpsi_pkg::*;
#(
  parameter int MAX_STACK = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  logic                      use_weights,
  input  logic                      use_support,
  input  logic                      use_accepted,
  input  logic [VALUE_W-1:0]        value,
  input  logic                      value_finite,
  input  logic [WEIGHT_W-1:0]       weight,
  input  logic                      weight_finite,
  input  logic [VALUE_W-1:0]        support,
  input  logic                      support_finite,
  input  logic                      accepted,
  input  logic                      stack_empty,
  output dp_stat_t                  stat,
  output logic [VALUE_W-1:0]        signal,
  output logic [SUPPORT_OUT_W-1:0]  support_out,
  output logic [STATUS_W-1:0]       status,
  output logic [COUNT_OUT_W-1:0]    candidate_count,
  output logic [COUNT_OUT_W-1:0]    accepted_count,
  output logic [COUNT_OUT_W-1:0]    finite_count,
  output logic [COUNT_OUT_W-1:0]    positive_weight_count
);

  localparam int CW  = $clog2(MAX_STACK + 1);
  localparam int PW  = VALUE_W + WEIGHT_W;
  localparam int SW  = PW + CW;
  localparam int WW  = WEIGHT_W - 1 + CW;
  localparam int DCW = $clog2(SW + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STACK);

  logic signed [SW-1:0]      wv_sum;
  logic [WW-1:0]             w_sum;
  logic signed [VALUE_W-1:0] support_max;
  logic [CW-1:0]             cand_cnt, acc_cnt, fin_cnt, pos_cnt;
  logic                      invalid;

  // Candidate classification.
  logic                      take, acc_eff, bad_vs, bad_w, zero_w, pos;
  logic [WEIGHT_W-2:0]       w_eff;
  logic signed [PW-1:0]      product;

  always_comb begin
    take    = !stack_empty && (cand_cnt < MAX_CNT);
    acc_eff = take && (use_accepted ? accepted : 1'b1);
    bad_vs  = !value_finite ||
              (use_support && (!support_finite || ($signed(support) <= 0)));
    bad_w   = use_weights && (!weight_finite || weight[WEIGHT_W-1]);
    zero_w  = use_weights && (weight == '0);
    pos     = acc_eff && !bad_vs && !bad_w && !zero_w;
    w_eff   = use_weights ? weight[WEIGHT_W-2:0] : ONE_Q8;
    product = $signed({1'b0, w_eff}) * $signed(value);
  end

  // Accumulators and counters.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wv_sum      <= '0;
      w_sum       <= '0;
      support_max <= '0;
      cand_cnt    <= '0;
      acc_cnt     <= '0;
      fin_cnt     <= '0;
      pos_cnt     <= '0;
      invalid     <= 1'b0;
    end else if (cmd.accum_en) begin
      if (take) cand_cnt <= cand_cnt + 1'b1;
      if (acc_eff) acc_cnt <= acc_cnt + 1'b1;
      if (acc_eff && !bad_vs) fin_cnt <= fin_cnt + 1'b1;
      if (acc_eff && (bad_vs || bad_w)) invalid <= 1'b1;
      if (pos) begin
        pos_cnt <= pos_cnt + 1'b1;
        wv_sum  <= wv_sum + {{CW{product[PW-1]}}, product};
        w_sum   <= w_sum + {{CW{1'b0}}, w_eff};
        if (use_support && ($signed(support) > support_max)) begin
          support_max <= $signed(support);
        end
      end
    end
  end

  // Status of the closed stack.
  always_comb begin
    priority if (cand_cnt == '0) status = ST_NO_CAND;
    else if (invalid)            status = ST_INVALID;
    else if (pos_cnt == '0)      status = (acc_cnt == '0) ? ST_ALL_REJECT : ST_ZERO_WEIGHT;
    else                         status = ST_OK;
  end

  // Restoring divider on the magnitude, one quotient bit a cycle.
  logic [SW-1:0]  dq;
  logic [WW-1:0]  rem;
  logic [DCW-1:0] dcnt;
  logic           neg;
  logic [WW:0]    rem_sh, rem_sub;
  logic           qbit;

  always_comb begin
    rem_sh  = {rem, dq[SW-1]};
    rem_sub = rem_sh - {1'b0, w_sum};
    qbit    = (rem_sh >= {1'b0, w_sum});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCW'(SW);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= wv_sum[SW-1];
      dq  <= wv_sum[SW-1] ? -wv_sum : wv_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[SW-2:0], qbit};
      rem <= qbit ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
    end
  end

  assign stat.div_needed = (status == ST_OK);
  assign stat.div_done   = (dcnt == '0);

  // Result fields; the mean always fits the value range.
  always_comb begin
    signal      = '0;
    support_out = '0;
    if (status == ST_OK) begin
      signal      = neg ? -dq[VALUE_W-1:0] : dq[VALUE_W-1:0];
      support_out = use_support ? support_max[SUPPORT_OUT_W-1:0] : ONE_Q16;
    end
  end

  // Counters reported modulo the output width.
  logic [CW+COUNT_OUT_W-1:0] cand_x, acc_x, fin_x, pos_x;

  always_comb begin
    cand_x                = {{COUNT_OUT_W{1'b0}}, cand_cnt};
    acc_x                 = {{COUNT_OUT_W{1'b0}}, acc_cnt};
    fin_x                 = {{COUNT_OUT_W{1'b0}}, fin_cnt};
    pos_x                 = {{COUNT_OUT_W{1'b0}}, pos_cnt};
    candidate_count       = cand_x[COUNT_OUT_W-1:0];
    accepted_count        = acc_x[COUNT_OUT_W-1:0];
    finite_count          = fin_x[COUNT_OUT_W-1:0];
    positive_weight_count = pos_x[COUNT_OUT_W-1:0];
  end

endmodule

// File: rtl/core/weighted_pixel_stack_integrator.sv
// ----------------------------------------------------------------------------
// weighted_pixel_stack_integrator
// Weighted mean of one pixel stack per result, in fixed point.
// ----------------------------------------------------------------------------
// Candidates of a pixel stack enter on in_ch, one per transaction, and the
// stack closes on a transaction with last or stack_empty set. One result per
// stack leaves on out_ch: mean, maximum support, status and five counts.
// Three single-bit registers on the APB port select weights, support and the
// accepted flag; write them only while the block is idle.
// A stack streams in at one candidate per clock. A closing transaction passes
// through a decision state and, when the status is ok, a divide in the
// restoring divider, one quotient bit per cycle, plus a final check that the
// count has run out; the result is then offered. in_ch.ready stays low from
// the closing transaction until the result transaction completes, so a
// stalled receiver holds the result steady and stops the input.
// Synchronous reset clears the registers, the accumulators and the controller;
// no result is pending after reset.
// ----------------------------------------------------------------------------
module weighted_pixel_stack_integrator
  import wpsi_pkg::*;
#(
  parameter int MAX_STACK = 256
) (
  input  logic               clk,
  input  logic               rst,
  wpsi_in_if.sink            in_ch,
  wpsi_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic     use_weights, use_support, use_accepted;
  logic     reg_wr;
  logic [1:0] reg_idx;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      use_weights  <= 1'b0;
      use_support  <= 1'b0;
      use_accepted <= 1'b0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_USE_WEIGHTS:  use_weights  <= pwdata[0];
        REG_USE_SUPPORT:  use_support  <= pwdata[0];
        REG_USE_ACCEPTED: use_accepted <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_USE_WEIGHTS:  prdata = {31'b0, use_weights};
      REG_USE_SUPPORT:  prdata = {31'b0, use_support};
      REG_USE_ACCEPTED: prdata = {31'b0, use_accepted};
      default:          prdata = '0;
    endcase
  end

  // Controller.
  wpsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_close  (in_ch.last || in_ch.stack_empty),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath.
  wpsi_datapath #(
    .MAX_STACK (MAX_STACK)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .use_weights           (use_weights),
    .use_support           (use_support),
    .use_accepted          (use_accepted),
    .value                 (in_ch.value),
    .value_finite          (in_ch.value_finite),
    .weight                (in_ch.weight),
    .weight_finite         (in_ch.weight_finite),
    .support               (in_ch.support),
    .support_finite        (in_ch.support_finite),
    .accepted              (in_ch.accepted),
    .stack_empty           (in_ch.stack_empty),
    .stat                  (stat),
    .signal                (out_ch.signal),
    .support_out           (out_ch.support_out),
    .status                (out_ch.status),
    .candidate_count       (out_ch.candidate_count),
    .accepted_count        (out_ch.accepted_count),
    .finite_count          (out_ch.finite_count),
    .positive_weight_count (out_ch.positive_weight_count)
  );

  assign out_ch.used_count = out_ch.positive_weight_count;

  // Assertions.
  `include "weighted_pixel_stack_integrator_assert.svh"

  `WPSI_ASSERT_SAME(a_no_input_while_result, out_ch.valid, !in_ch.ready, "input open while a result waits")
  `WPSI_ASSERT_SAME(a_ok_has_used, out_ch.valid && (out_ch.status == ST_OK), out_ch.used_count != '0 || out_ch.candidate_count == '0, "ok result with no used sample")
  `WPSI_ASSERT_SAME(a_fail_zero_payload, out_ch.valid && (out_ch.status != ST_OK), (out_ch.signal == '0) && (out_ch.support_out == '0), "failed stack with non-zero mean or support")
  `WPSI_ASSERT_NEXT(a_one_result, out_ch.valid && out_ch.ready, !out_ch.valid, "result repeated after its transaction")

endmodule
